/* src/integer_to_ascii_digits_macros.svh */
// Assertion macros shared by the integer to ASCII converter.
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, sampled on clk_i and disabled during reset.
`define I2A_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
// Same-cycle implication.
`define I2A_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// Next-cycle implication.
`define I2A_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define I2A_ASSERT(name, prop)
`define I2A_ASSERT_IMPL(name, ante, cons)
`define I2A_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* src/i2a_pkg.sv */
// Types, codes and the character table of the integer to ASCII converter.
`default_nettype none
package i2a_pkg;

  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned CHAR_W     = 8;

  // Opcodes. The unnamed code 1 behaves as unsigned decimal; OP_HEX_ALT behaves as hexadecimal.
  localparam logic [OPCODE_W-1:0] OP_SDEC    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_HEX     = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_HEX_ALT = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [CHAR_W-1:0] DIGIT_SET [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Input request and output character.
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [OPCODE_W-1:0]   opcode;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic skip_one;
    logic skip_grp;
    logic emit_sign;
    logic emit_digit;
  } i2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic grp_zero;
    logic cnt_gt1;
    logic cnt_gt_grp;
    logic last_digit;
    logic neg;
    logic out_free;
  } i2a_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d);
    return DIGIT_SET[d];
  endfunction

endpackage
`default_nettype wire

/* src/i2a_ctrl.sv */
// Controller state machine of the integer to ASCII converter.
`default_nettype none
module i2a_ctrl import i2a_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire i2a_sts_t sts_i,
  output i2a_cmd_t      cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   skip_grp;
  logic   skip_one;

  // Leading zero removal: a whole group when possible, else one digit.
  assign skip_grp = sts_i.grp_zero && sts_i.cnt_gt_grp;
  assign skip_one = !skip_grp && sts_i.top_zero && sts_i.cnt_gt1;

  assign busy_o = (state_q != ST_IDLE);

  // Commands decoded from the state and the status.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.load       = in_valid_i;
      ST_CONV: cmd_o.step       = !sts_i.conv_done;
      ST_SKIP: begin
        cmd_o.skip_grp = skip_grp;
        cmd_o.skip_one = skip_one;
      end
      ST_SIGN: cmd_o.emit_sign  = sts_i.out_free;
      ST_EMIT: cmd_o.emit_digit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CONV;
        end
        ST_CONV: begin
          if (sts_i.conv_done) state_q <= ST_SKIP;
        end
        ST_SKIP: begin
          if (!skip_grp && !skip_one) state_q <= sts_i.neg ? ST_SIGN : ST_EMIT;
        end
        ST_SIGN: begin
          if (sts_i.out_free) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.out_free && sts_i.last_digit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/i2a_datapath.sv */
// Datapath: magnitude, shift-add-3 digit conversion and output register.
`default_nettype none
module i2a_datapath import i2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_req_t  in_req_i,
  input  wire i2a_cmd_t cmd_i,
  output i2a_sts_t      sts_o,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output out_rsp_t      out_rsp_o
);

  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned HD        = (VALUE_BITS + 3) / 4;
  localparam int unsigned MAG_W     = HD * 4;
  localparam int unsigned NSTEPS    = MAG_W / BITS_PER_STEP;
  // Decimal digits of the largest value: floor(bits * log10(2)) + 1.
  localparam int unsigned ND        = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W     = ND * 4;
  localparam int unsigned HEX_SHIFT = (ND - HD) * 4;
  localparam int unsigned GRP       = (ND >= 4) ? 4 : 1;
  localparam int unsigned CNT_W     = $clog2(ND + 1);
  localparam int unsigned STEP_W    = $clog2(NSTEPS + 1);

  logic [MAG_W-1:0]      bin_q, bin_d, bin_step;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_step;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [STEP_W-1:0]     steps_q, steps_d;
  logic                  out_valid_q, out_valid_d;
  out_rsp_t              out_q, out_d;
  logic [VALUE_BITS-1:0] in_v, in_mag;
  logic                  in_neg, in_hex;
  logic [3:0]            top_digit;

  // Operand decode: negative signed values are negated to their unsigned magnitude.
  assign in_v   = in_req_i.value[VALUE_BITS-1:0];
  assign in_neg = (in_req_i.opcode == OP_SDEC) && in_v[VALUE_BITS-1];
  assign in_hex = (in_req_i.opcode == OP_HEX) || (in_req_i.opcode == OP_HEX_ALT);
  assign in_mag = in_neg ? (~in_v + VALUE_BITS'(1)) : in_v;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // One conversion step: shift four binary bits into the BCD digits.
  always_comb begin
    bcd_step = bcd_q;
    bin_step = bin_q;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], bin_step[MAG_W-1]};
      bin_step = {bin_step[MAG_W-2:0], 1'b0};
    end
  end

  // Next state of the digit registers.
  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    steps_d = steps_q;
    if (cmd_i.load) begin
      neg_d = in_neg;
      if (in_hex) begin
        // Hex digits are the magnitude's nibbles, aligned to the top.
        bcd_d   = BCD_W'(MAG_W'(in_mag)) << HEX_SHIFT;
        bin_d   = '0;
        steps_d = '0;
        cnt_d   = CNT_W'(HD);
      end else begin
        bcd_d   = '0;
        bin_d   = MAG_W'(in_mag);
        steps_d = STEP_W'(NSTEPS);
        cnt_d   = CNT_W'(ND);
      end
    end else if (cmd_i.step) begin
      bcd_d   = bcd_step;
      bin_d   = bin_step;
      steps_d = steps_q - STEP_W'(1);
    end else if (cmd_i.skip_grp) begin
      bcd_d = bcd_q << (4 * GRP);
      cnt_d = cnt_q - CNT_W'(GRP);
    end else if (cmd_i.skip_one || cmd_i.emit_digit) begin
      bcd_d = bcd_q << 4;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Output register: holds a character until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i.emit_sign) begin
      out_valid_d      = 1'b1;
      out_d.digit_char = CHAR_MINUS;
      out_d.last       = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d      = 1'b1;
      out_d.digit_char = digit_to_char(top_digit);
      out_d.last       = (cnt_q == CNT_W'(1));
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.conv_done  = (steps_q == '0);
    sts_o.top_zero   = (top_digit == 4'd0);
    sts_o.grp_zero   = (bcd_q[BCD_W-1 -: 4*GRP] == '0);
    sts_o.cnt_gt1    = (cnt_q > CNT_W'(1));
    sts_o.cnt_gt_grp = (cnt_q > CNT_W'(GRP));
    sts_o.last_digit = (cnt_q == CNT_W'(1));
    sts_o.neg        = neg_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

/* src/integer_to_ascii_digits.sv */
// Integer to ASCII text converter, top level.
// Sequence: a load; in decimal modes the shift-add-3 conversion steps, in hex mode none;
// then leading zero removal; then a minus sign for a negative operand and one character
// at a time, each taken as the output register frees.
// Throughput: one request at a time, set by the four-bit-per-cycle conversion loop and
// the one-character output register; output stalls hold back the character output.
`default_nettype none
`include "integer_to_ascii_digits_macros.svh"
module integer_to_ascii_digits import i2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_rsp_t     out_rsp_o
);

  // Reset clears the controller, the step and digit counters and the output valid; no memory needs clearing.

  i2a_cmd_t   cmd;
  i2a_sts_t   sts;
  logic       busy;
  logic [5:0] cmd_vec;

  // Sequencing of load, conversion, zero removal and character output.
  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Digit registers and output register.
  i2a_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_stall_o = busy;

  assign cmd_vec = {cmd.load, cmd.step, cmd.skip_one, cmd.skip_grp,
                    cmd.emit_sign, cmd.emit_digit};

  // The controller never issues two commands in one cycle.
  `I2A_ASSERT(a_cmd_onehot, $onehot0(cmd_vec))
  // A new request only arrives once the previous conversion has finished.
  `I2A_ASSERT_IMPL(a_accept_conv_done, in_valid_i && !in_stall_o, sts.conv_done)
  // A minus sign is only produced for a negative operand.
  `I2A_ASSERT_IMPL(a_sign_only_neg, cmd.emit_sign, sts.neg)
  // After the last character is loaded the block takes requests again.
  `I2A_ASSERT_NEXT(a_last_frees_input, cmd.emit_digit && sts.last_digit, !in_stall_o)

endmodule
`default_nettype wire
